FILE: design/slfl_pkg.sv
// Shared types and constants for the sharded LRU frame lookup.
// No dependencies; imported by every module of the block.
package slfl_pkg;

    // Fixed field widths of the request and result items
    localparam int BLOCK_W     = 31;
    localparam int FRAME_OUT_W = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Load enables for the two shard-select stages
    typedef struct packed {
        logic load_s0;
        logic load_s1;
    } stage_load_t;

    // Occupancy of the two shard-select stages
    typedef struct packed {
        logic valid_s0;
        logic valid_s1;
    } stage_valid_t;

    // One lookup result
    typedef struct packed {
        logic [BLOCK_W-1:0]     load_block;
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame_index;
    } lookup_result_t;

endpackage

FILE: design/slfl_shard_sel.sv
// Shard select: block number modulo the shard count, by reciprocal multiply.
// Two pipeline stages (quotient estimate, then remainder with one correction).
// Depends on slfl_pkg.
module slfl_shard_sel #(
    parameter int NUM_SHARDS = 4,
    parameter int SHARD_W    = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slfl_pkg::stage_load_t        load,
    input  logic                         in_valid,
    input  logic [slfl_pkg::BLOCK_W-1:0] in_block,
    output slfl_pkg::stage_valid_t       valid,
    output logic [slfl_pkg::BLOCK_W-1:0] block_s1,
    output logic [SHARD_W-1:0]           shard_s1
);
    import slfl_pkg::*;

    // Reciprocal with shift BLOCK_W + ceil(log2 count); fits 32 bits
    localparam int DIV_L = $clog2(NUM_SHARDS);
    localparam int DIV_S = BLOCK_W + DIV_L;
    localparam longint unsigned RECIP_WIDE = (64'd1 << DIV_S) / NUM_SHARDS;
    localparam logic [31:0] RECIP = 32'(RECIP_WIDE);
    localparam int PROD_W = BLOCK_W + 32;
    localparam int REM_W  = BLOCK_W + 12;

    logic               valid_s0_reg;
    logic               valid_s1_reg;
    logic [BLOCK_W-1:0] block_s0_reg;
    logic [BLOCK_W-1:0] block_s1_reg;
    logic [BLOCK_W-1:0] quot_s1_reg;
    logic [BLOCK_W-1:0] quot_next;
    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   quot_times;
    logic [REM_W-1:0]   rem_raw;
    logic [REM_W-1:0]   rem_fix;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s0_reg <= 1'b0;
            valid_s1_reg <= 1'b0;
        end
        else
        begin
            if (load.load_s0)
                valid_s0_reg <= in_valid;
            if (load.load_s1)
                valid_s1_reg <= valid_s0_reg;
        end
    end

    // Quotient estimate, low by at most one
    always_comb
    begin
        prod      = PROD_W'(block_s0_reg) * PROD_W'(RECIP);
        quot_next = BLOCK_W'(prod >> DIV_S);
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load.load_s0)
            block_s0_reg <= in_block;
        if (load.load_s1)
        begin
            block_s1_reg <= block_s0_reg;
            quot_s1_reg  <= quot_next;
        end
    end

    // Remainder with a single correction step
    always_comb
    begin
        quot_times = REM_W'(quot_s1_reg) * REM_W'(NUM_SHARDS);
        rem_raw    = REM_W'(block_s1_reg) - quot_times;
        if (rem_raw >= REM_W'(NUM_SHARDS))
            rem_fix = rem_raw - REM_W'(NUM_SHARDS);
        else
            rem_fix = rem_raw;
    end

    assign shard_s1       = SHARD_W'(rem_fix);
    assign block_s1       = block_s1_reg;
    assign valid.valid_s0 = valid_s0_reg;
    assign valid.valid_s1 = valid_s1_reg;

endmodule

FILE: design/slfl_row_store.sv
// Per-shard row memory: tags, valid flags and ranks of all frames of a shard.
// Registered read, one write port, last-write forwarding, row init bits.
// Depends on slfl_pkg.
module slfl_row_store #(
    parameter int NUM_SHARDS = 4,
    parameter int SHARD_W    = 2,
    parameter int SHARD_SIZE = 16,
    parameter int SLOT_W     = 4,
    parameter int ROW_W      = 576
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [SHARD_W-1:0] rd_shard,
    input  logic               wr_en,
    input  logic [ROW_W-1:0]   wr_row,
    output logic [SHARD_W-1:0] row_shard,
    output logic [ROW_W-1:0]   row
);
    import slfl_pkg::*;

    // Entry layout, lowest bits first: rank, tag, valid
    localparam int ENT_W = 1 + BLOCK_W + SLOT_W;

    logic [ROW_W-1:0]      mem [NUM_SHARDS];
    logic [NUM_SHARDS-1:0] row_init_reg;
    logic [ROW_W-1:0]      rdata_reg;
    logic                  rinit_reg;
    logic [SHARD_W-1:0]    rshard_reg;
    logic [ROW_W-1:0]      fwd_row_reg;
    logic [SHARD_W-1:0]    fwd_shard_reg;
    logic                  fwd_valid_reg;
    logic [ROW_W-1:0]      reset_row;

    // Row after reset: nothing held, ranks equal slot order
    always_comb
    begin
        reset_row = '0;
        for (int j = 0; j < SHARD_SIZE; j++)
            reset_row[j*ENT_W +: SLOT_W] = SLOT_W'(j);
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[rshard_reg] <= wr_row;
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_shard];
            rshard_reg <= rd_shard;
        end
        if (wr_en)
        begin
            fwd_row_reg   <= wr_row;
            fwd_shard_reg <= rshard_reg;
        end
    end

    // Control: row init bits, read init flag, forward valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg  <= '0;
            rinit_reg     <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_init_reg[rshard_reg] <= 1'b1;
                fwd_valid_reg            <= 1'b1;
            end
            if (rd_en)
                rinit_reg <= row_init_reg[rd_shard];
        end
    end

    // Latest write wins over a stale read; unwritten rows read as reset
    always_comb
    begin
        if (fwd_valid_reg && (fwd_shard_reg == rshard_reg))
            row = fwd_row_reg;
        else if (rinit_reg)
            row = rdata_reg;
        else
            row = reset_row;
    end

    assign row_shard = rshard_reg;

endmodule

FILE: design/slfl_lru_update.sv
// Lookup and true-LRU update over one shard row: tag match, victim pick,
// rank shift and retag. Purely combinational. Depends on slfl_pkg.
module slfl_lru_update #(
    parameter int SHARD_SIZE = 16,
    parameter int SLOT_W     = 4,
    parameter int ROW_W      = 576
) (
    input  logic [ROW_W-1:0]             row,
    input  logic [slfl_pkg::BLOCK_W-1:0] block,
    output logic [ROW_W-1:0]             new_row,
    output logic [SLOT_W-1:0]            slot,
    output logic                         hit
);
    import slfl_pkg::*;

    localparam int ENT_W = 1 + BLOCK_W + SLOT_W;
    localparam int TAG_LO = SLOT_W;
    localparam int VLD_BIT = SLOT_W + BLOCK_W;
    localparam logic [SLOT_W-1:0] LAST_RANK = SLOT_W'(SHARD_SIZE - 1);

    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] victim_slot;
    logic [SLOT_W-1:0] found_rank;
    logic [SLOT_W-1:0] rank_j;

    // First valid tag match, and the least recent slot
    always_comb
    begin
        hit         = 1'b0;
        hit_slot    = '0;
        victim_slot = '0;
        for (int j = 0; j < SHARD_SIZE; j++)
        begin
            if (!hit && row[j*ENT_W + VLD_BIT]
                && (row[j*ENT_W + TAG_LO +: BLOCK_W] == block))
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(j);
            end
            if (row[j*ENT_W +: SLOT_W] == LAST_RANK)
                victim_slot = SLOT_W'(j);
        end
        slot = hit ? hit_slot : victim_slot;
    end

    // Promote the chosen slot; more recent ones move back by one
    always_comb
    begin
        found_rank = row[slot*ENT_W +: SLOT_W];
        new_row    = row;
        for (int j = 0; j < SHARD_SIZE; j++)
        begin
            rank_j = row[j*ENT_W +: SLOT_W];
            if (SLOT_W'(j) == slot)
            begin
                new_row[j*ENT_W +: SLOT_W] = '0;
                if (!hit)
                begin
                    new_row[j*ENT_W + TAG_LO +: BLOCK_W] = block;
                    new_row[j*ENT_W + VLD_BIT]           = 1'b1;
                end
            end
            else if (rank_j < found_rank)
                new_row[j*ENT_W +: SLOT_W] = rank_j + SLOT_W'(1);
        end
    end

endmodule

FILE: design/sharded_lru_frame_lookup.sv
// Sharded LRU frame lookup. One request per cycle sustained unless m_tready stalls
// the result; from input transfer to result register a request passes the second
// shard-select stage, the row memory read, then the lookup and row write-back.
// Back-to-back requests to one shard see each other through write forwarding.
// Reset (rst_n, async) empties the pipeline and marks every shard row unwritten,
// so all frames read as empty with ranks in slot order; no clearing pass.
module sharded_lru_frame_lookup #(
    parameter int TOTAL_FRAMES     = 64,
    parameter int FRAMES_PER_SHARD = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: block_number[30:0], zero pad [31]
    input  logic [slfl_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: frame_index[5:0], hit[6], load_block[37:7], zero pad [39:38]
    output logic [slfl_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import slfl_pkg::*;

    localparam int SHARD_SIZE = (FRAMES_PER_SHARD > TOTAL_FRAMES) ?
                                TOTAL_FRAMES : FRAMES_PER_SHARD;
    localparam int NUM_SHARDS = TOTAL_FRAMES / SHARD_SIZE;
    localparam int SHARD_W    = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
    localparam int SLOT_W     = $clog2(SHARD_SIZE);
    localparam int ROW_W      = SHARD_SIZE * (1 + BLOCK_W + SLOT_W);

    stage_load_t        sel_load;
    stage_valid_t       sel_valid;
    logic [BLOCK_W-1:0] block_s1;
    logic [SHARD_W-1:0] shard_s1;
    logic               out_en;
    logic               load_s2;
    logic               valid_s2_reg;
    logic [BLOCK_W-1:0] block_s2_reg;
    logic [SHARD_W-1:0] row_shard;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   new_row;
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic [31:0]        global_frame;
    logic               out_valid_reg;
    lookup_result_t     result_reg;
    lookup_result_t     result_next;

    // Stall chain: each stage moves when the next one has room
    always_comb
    begin
        out_en           = !out_valid_reg || m_tready;
        load_s2          = !valid_s2_reg || out_en;
        sel_load.load_s1 = !sel_valid.valid_s1 || load_s2;
        sel_load.load_s0 = !sel_valid.valid_s0 || sel_load.load_s1;
    end

    assign s_tready = sel_load.load_s0;

    slfl_shard_sel #(
        .NUM_SHARDS (NUM_SHARDS),
        .SHARD_W    (SHARD_W)
    ) u_shard_sel (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (sel_load),
        .in_valid (s_tvalid),
        .in_block (s_tdata[BLOCK_W-1:0]),
        .valid    (sel_valid),
        .block_s1 (block_s1),
        .shard_s1 (shard_s1)
    );

    slfl_row_store #(
        .NUM_SHARDS (NUM_SHARDS),
        .SHARD_W    (SHARD_W),
        .SHARD_SIZE (SHARD_SIZE),
        .SLOT_W     (SLOT_W),
        .ROW_W      (ROW_W)
    ) u_row_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (load_s2),
        .rd_shard  (shard_s1),
        .wr_en     (valid_s2_reg && out_en),
        .wr_row    (new_row),
        .row_shard (row_shard),
        .row       (row)
    );

    slfl_lru_update #(
        .SHARD_SIZE (SHARD_SIZE),
        .SLOT_W     (SLOT_W),
        .ROW_W      (ROW_W)
    ) u_lru_update (
        .row     (row),
        .block   (block_s2_reg),
        .new_row (new_row),
        .slot    (slot),
        .hit     (hit)
    );

    // Lookup stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_s2_reg <= 1'b0;
        else if (load_s2)
            valid_s2_reg <= sel_valid.valid_s1;
    end

    always_ff @(posedge clk)
    begin
        if (load_s2)
            block_s2_reg <= block_s1;
    end

    // Result formatting
    always_comb
    begin
        global_frame            = 32'(row_shard) * 32'(SHARD_SIZE) + 32'(slot);
        result_next.frame_index = global_frame[FRAME_OUT_W-1:0];
        result_next.hit         = hit;
        result_next.load_block  = hit ? '0 : block_s2_reg;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= valid_s2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && valid_s2_reg)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);

endmodule

FILE: verif/tb_sharded_lru_frame_lookup.sv
// Self-checking testbench for sharded_lru_frame_lookup: stream requests in,
// predict frame/hit/load per request, compare every result transfer in order.
// Depends on slfl_pkg and the sharded_lru_frame_lookup RTL.
module tb_sharded_lru_frame_lookup;

    import slfl_pkg::*;

    localparam int POOL_FRAMES  = 64;
    localparam int SHARD_FRAMES = 16;
    localparam int SHARD_CNT    = POOL_FRAMES / SHARD_FRAMES;
    localparam int HOT_BLOCKS   = 80;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the frame table
    logic [BLOCK_W-1:0] held_block [POOL_FRAMES];
    logic               resident   [POOL_FRAMES];
    int unsigned        age        [POOL_FRAMES];

    lookup_result_t expected_results[$];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold   = 0;
    int errors    = 0;
    int sent_count  = 0;
    int hit_count   = 0;
    int miss_count  = 0;

    sharded_lru_frame_lookup #(
        .TOTAL_FRAMES     (POOL_FRAMES),
        .FRAMES_PER_SHARD (SHARD_FRAMES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Idle length: none in steady mode; else mostly none or short, now and then long
    function automatic int idle_length(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Look up one block in the shadow table, update LRU order, return result
    function automatic lookup_result_t lookup_frame(input logic [BLOCK_W-1:0] blk);
        lookup_result_t res;
        int unsigned    base;
        int unsigned    slot;
        int unsigned    old_age;
        bit             found;
        base  = (blk % SHARD_CNT) * SHARD_FRAMES;
        slot  = base;
        found = 1'b0;
        for (int i = 0; i < SHARD_FRAMES; i++)
        begin
            if (!found && resident[base + i] && held_block[base + i] == blk)
            begin
                found = 1'b1;
                slot  = base + i;
            end
        end
        // miss: retag the least recent frame of the shard
        if (!found)
        begin
            for (int i = 0; i < SHARD_FRAMES; i++)
            begin
                if (age[base + i] == SHARD_FRAMES - 1)
                    slot = base + i;
            end
            held_block[slot] = blk;
            resident[slot]   = 1'b1;
        end
        old_age = age[slot];
        for (int i = 0; i < SHARD_FRAMES; i++)
        begin
            if (age[base + i] < old_age)
                age[base + i]++;
        end
        age[slot] = 0;
        res.frame_index = FRAME_OUT_W'(slot);
        res.hit         = found;
        res.load_block  = found ? '0 : blk;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    // One request transfer; called and returns at a falling edge
    task automatic send_block(input logic [IN_TDATA_W-1:0] word);
        int             gap;
        lookup_result_t pred;
        gap = idle_length(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        pred = lookup_frame(word[BLOCK_W-1:0]);
        expected_results.insert(expected_results.size(), pred);
        sent_count++;
        @(negedge clk);
    endtask

    // Result side: random backpressure
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold  <= idle_length(rx_steady);
        end
    end

    // Result checker
    always @(posedge clk)
    begin : result_check
        lookup_result_t got;
        lookup_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = lookup_result_t'(m_tdata[$bits(lookup_result_t)-1:0]);
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result transfer %h", m_tdata));
            else
            begin
                want = expected_results.pop_front();
                if (got.frame_index !== want.frame_index)
                    report_mismatch($sformatf("frame_index got %0d want %0d",
                                              got.frame_index, want.frame_index));
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("hit got %b want %b", got.hit, want.hit));
                if (got.load_block !== want.load_block)
                    report_mismatch($sformatf("load_block got %h want %h",
                                              got.load_block, want.load_block));
                if (want.hit)
                    hit_count++;
                else
                    miss_count++;
            end
        end
    end

    // Empty pool: tag zero must not hit an invalid frame
    task automatic test_empty_pool();
        send_block(32'd0);
        send_block(32'd4);
        send_block(32'd0);
    endtask

    // Field extremes and the ignored pad bit
    task automatic test_block_extremes();
        send_block({1'b0, 31'h7FFF_FFFF});
        send_block({1'b1, 31'h7FFF_FFFF});
        send_block({1'b1, 31'd1});
        send_block({1'b0, 31'h4000_0000});
    endtask

    // Fill one shard, refresh its oldest frame, then force an eviction
    task automatic test_shard_eviction();
        for (int k = 0; k < SHARD_FRAMES; k++)
            send_block({1'b0, 31'h2000_0002 + 31'(4 * k)});
        send_block({1'b0, 31'h2000_0002});
        send_block({1'b0, 31'h2000_0002 + 31'(4 * SHARD_FRAMES)});
    endtask

    // Mostly a churning hot set, with repeats, same-shard neighbors and noise
    task automatic test_random_locality(input int count);
        logic [BLOCK_W-1:0] hot [HOT_BLOCKS];
        logic [BLOCK_W-1:0] blk;
        logic [BLOCK_W-1:0] prev;
        int                 r;
        for (int k = 0; k < HOT_BLOCKS; k++)
            hot[k] = BLOCK_W'($urandom());
        prev = hot[0];
        for (int n = 0; n < count; n++)
        begin
            if (n % 250 == 0)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                blk = prev;
            else if (r < 14)
                blk = prev + BLOCK_W'(SHARD_CNT * $urandom_range(1, 3));
            else if (r < 84)
                blk = hot[$urandom_range(0, HOT_BLOCKS - 1)];
            else if (r < 87)
                blk = ($urandom_range(0, 1) == 0) ? '0 : '1;
            else
                blk = BLOCK_W'($urandom());
            if ($urandom_range(0, 99) < 4)
                hot[$urandom_range(0, HOT_BLOCKS - 1)] = BLOCK_W'($urandom());
            send_block({1'($urandom_range(0, 15) == 0), blk});
            prev = blk;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < POOL_FRAMES; i++)
        begin
            held_block[i] = '0;
            resident[i]   = 1'b0;
            age[i]        = i % SHARD_FRAMES;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_pool();
        test_block_extremes();
        test_shard_eviction();
        test_random_locality(1750);
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d lookups (%0d hits, %0d misses) under random stalls on both sides.",
                 sent_count, hit_count, miss_count);
        $display("Mismatches: %0d", errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
